FILE: rtl/odo_pkg.sv
// Shared types, constants and helpers for the differential-drive odometry block.
// No dependencies; imported by odo_cordic, odo_mul and diff_drive_odometry_unit.
package odo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int ITER_W       = $clog2(CORDIC_ITERS + 1);
    localparam int ATAN_IDX_W   = 5;

    localparam int ANGLE_W = 24;
    localparam int Z_W     = 25;
    localparam int XY_W    = 32;
    localparam int TRIG_W  = 33;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic signed [XY_W-1:0]  CORDIC_GAIN_INV = 32'sh26DD3B6A;
    localparam logic signed [MUL_W-1:0] HEADING_SCALE   = 33'sd42722830;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VDT,
        ST_DIF,
        ST_HDG,
        ST_HUPD,
        ST_WAIT,
        ST_MX,
        ST_MY,
        ST_ACCY,
        ST_DONE
    } odo_state_t;

    typedef struct packed {
        logic               start;
        logic [ANGLE_W-1:0] angle;
    } odo_cordic_req_t;

    // arctangent of 2^-i in heading counts
    function automatic logic [21:0] atan_count(input logic [ATAN_IDX_W-1:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2097152;
            5'd1:    v = 22'd1238021;
            5'd2:    v = 22'd654136;
            5'd3:    v = 22'd332050;
            5'd4:    v = 22'd166669;
            5'd5:    v = 22'd83416;
            5'd6:    v = 22'd41718;
            5'd7:    v = 22'd20860;
            5'd8:    v = 22'd10430;
            5'd9:    v = 22'd5215;
            5'd10:   v = 22'd2608;
            5'd11:   v = 22'd1304;
            5'd12:   v = 22'd652;
            5'd13:   v = 22'd326;
            5'd14:   v = 22'd163;
            5'd15:   v = 22'd81;
            5'd16:   v = 22'd41;
            5'd17:   v = 22'd20;
            5'd18:   v = 22'd10;
            5'd19:   v = 22'd5;
            5'd20:   v = 22'd3;
            5'd21:   v = 22'd1;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/odo_cordic.sv
// Iterative rotation-mode CORDIC: one shift/add step per cycle, then quadrant fold.
// Depends on odo_pkg.
module odo_cordic (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  odo_pkg::odo_cordic_req_t        req,
    output logic                            busy,
    output logic signed [odo_pkg::TRIG_W-1:0] cos_out,
    output logic signed [odo_pkg::TRIG_W-1:0] sin_out
);
    import odo_pkg::*;

    logic                     busy_reg, busy_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [1:0]               quad_reg, quad_next;
    logic signed [TRIG_W-1:0] cos_reg, cos_next;
    logic signed [TRIG_W-1:0] sin_reg, sin_next;

    logic signed [XY_W-1:0]   dx, dy;
    logic signed [Z_W-1:0]    atan_s;
    logic signed [TRIG_W-1:0] xe, ye;
    logic                     last;

    assign dx     = y_reg >>> iter_reg;
    assign dy     = x_reg >>> iter_reg;
    assign atan_s = {3'b000, atan_count(ATAN_IDX_W'(iter_reg))};
    assign xe     = {x_reg[XY_W-1], x_reg};
    assign ye     = {y_reg[XY_W-1], y_reg};
    assign last   = (iter_reg == ITER_W'(CORDIC_ITERS));

    always_comb begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        quad_next = quad_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            iter_next = '0;
            x_next    = CORDIC_GAIN_INV;
            y_next    = '0;
            z_next    = {3'b000, req.angle[21:0]};
            quad_next = req.angle[23:22];
        end else if (busy_reg) begin
            if (last) begin
                // fold the first-quadrant result into the quadrant of the angle
                busy_next = 1'b0;
                case (quad_reg)
                    2'd0: begin cos_next = xe;  sin_next = ye;  end
                    2'd1: begin cos_next = -ye; sin_next = xe;  end
                    2'd2: begin cos_next = -xe; sin_next = -ye; end
                    default: begin cos_next = ye; sin_next = -xe; end
                endcase
            end else begin
                iter_next = iter_reg + 1'b1;
                if (!z_reg[Z_W-1]) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_s;
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_s;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign busy    = busy_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.start && !busy_reg) |=> busy_reg)
        else $error("cordic did not start");
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (iter_reg <= ITER_W'(CORDIC_ITERS)))
        else $error("cordic iteration count overran");
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && last) |=> !busy_reg)
        else $error("cordic did not finish after last step");

endmodule

FILE: rtl/odo_mul.sv
// Shared signed multiplier with registered product, one product per cycle.
// Depends on odo_pkg.
module odo_mul (
    input  logic                              aclk,
    input  logic signed [odo_pkg::MUL_W-1:0]  op_a,
    input  logic signed [odo_pkg::MUL_W-1:0]  op_b,
    output logic signed [odo_pkg::PROD_W-1:0] product
);
    import odo_pkg::*;

    logic signed [PROD_W-1:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

FILE: rtl/diff_drive_odometry_unit.sv
// Differential-drive odometry: sequencer, state accumulators and result register.
// A request runs ST_VDT, ST_DIF, ST_HDG, ST_HUPD, ST_WAIT, ST_MX, ST_MY, ST_ACCY,
// ST_DONE, waiting for the iterative CORDIC and m_ready; the next is taken only in
// ST_IDLE. A shared multiplier does five products a request; three overlap the CORDIC.
// Synchronous active-low reset clears position and heading to zero, no result pending.
// Depends on odo_pkg, odo_cordic, odo_mul.
module diff_drive_odometry_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_left_speed,
    input  logic signed [15:0] s_right_speed,
    input  logic [15:0]        s_dt_ticks,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic [23:0]        m_heading,
    output logic signed [15:0] m_lin_speed,
    output logic signed [19:0] m_yaw_rate
);
    import odo_pkg::*;

    odo_state_t state_reg, state_next;

    logic signed [15:0]       l_reg, r_reg;
    logic [15:0]              dt_reg;
    logic signed [MUL_W-1:0]  vdt_reg;
    logic signed [31:0]       x_reg, x_next;
    logic signed [31:0]       y_reg, y_next;
    logic [ANGLE_W-1:0]       heading_reg, heading_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [31:0]       out_x_reg, out_y_reg;
    logic [23:0]              out_h_reg;
    logic signed [15:0]       out_v_reg;
    logic signed [19:0]       out_w_reg;

    // sequencer outputs
    logic ld_in, ld_vdt, ld_head, ld_x, ld_y, ld_out;
    logic signed [MUL_W-1:0] op_a, op_b;

    odo_cordic_req_t          cordic_req;
    logic                     cordic_busy;
    logic signed [TRIG_W-1:0] cos_val, sin_val;
    logic signed [PROD_W-1:0] prod;

    logic signed [16:0]       sum_lr, diff_rl;
    logic signed [15:0]       lin_v;
    logic signed [19:0]       yaw_w;
    logic signed [PROD_W-1:0] rnd_pos, rnd_head;
    logic signed [32:0]       pos_delta;

    assign sum_lr  = {l_reg[15], l_reg} + {r_reg[15], r_reg};
    assign diff_rl = {r_reg[15], r_reg} - {l_reg[15], l_reg};
    assign lin_v   = sum_lr[16:1];
    assign yaw_w   = {diff_rl, 3'b000};

    // product scale 2^-58 m -> Q16.16 with round half up
    assign rnd_pos   = prod + (PROD_W'(1) <<< 41);
    assign pos_delta = {{9{rnd_pos[PROD_W-1]}}, rnd_pos[65:42]};
    // (d * K) * 8 / 2^32, rounded half up
    assign rnd_head  = prod + (PROD_W'(1) <<< 28);

    assign heading_next = heading_reg + rnd_head[52:29];
    assign x_next       = sat32({x_reg[31], x_reg} + pos_delta);
    assign y_next       = sat32({y_reg[31], y_reg} + pos_delta);

    odo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cordic_req),
        .busy    (cordic_busy),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    odo_mul u_mul (
        .aclk    (aclk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (prod)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_VDT;
            ST_VDT:  state_next = ST_DIF;
            ST_DIF:  state_next = ST_HDG;
            ST_HDG:  state_next = ST_HUPD;
            ST_HUPD: state_next = ST_WAIT;
            ST_WAIT: if (!cordic_busy) state_next = ST_MX;
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_ACCY;
            ST_ACCY: state_next = ST_DONE;
            ST_DONE: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        ld_in            = 1'b0;
        ld_vdt           = 1'b0;
        ld_head          = 1'b0;
        ld_x             = 1'b0;
        ld_y             = 1'b0;
        ld_out           = 1'b0;
        op_a             = '0;
        op_b             = '0;
        cordic_req.start = 1'b0;
        cordic_req.angle = heading_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready          = 1'b1;
                ld_in            = s_valid;
                cordic_req.start = s_valid;
            end
            ST_VDT: begin
                op_a = {{17{lin_v[15]}}, lin_v};
                op_b = {17'b0, dt_reg};
            end
            ST_DIF: begin
                ld_vdt = 1'b1;
                op_a   = {{16{diff_rl[16]}}, diff_rl};
                op_b   = {17'b0, dt_reg};
            end
            ST_HDG: begin
                op_a = prod[MUL_W-1:0];
                op_b = HEADING_SCALE;
            end
            ST_HUPD: ld_head = 1'b1;
            ST_WAIT: ;
            ST_MX: begin
                op_a = vdt_reg;
                op_b = cos_val;
            end
            ST_MY: begin
                ld_x = 1'b1;
                op_a = vdt_reg;
                op_b = sin_val;
            end
            ST_ACCY: ld_y = 1'b1;
            ST_DONE: ld_out = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ld_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            x_reg       <= '0;
            y_reg       <= '0;
            heading_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (ld_x)    x_reg       <= x_next;
            if (ld_y)    y_reg       <= y_next;
            if (ld_head) heading_reg <= heading_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_in) begin
            l_reg  <= s_left_speed;
            r_reg  <= s_right_speed;
            dt_reg <= s_dt_ticks;
        end
        if (ld_vdt) vdt_reg <= prod[MUL_W-1:0];
        if (ld_out) begin
            out_x_reg <= x_reg;
            out_y_reg <= y_reg;
            out_h_reg <= heading_reg;
            out_v_reg <= lin_v;
            out_w_reg <= yaw_w;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pos_x     = out_x_reg;
    assign m_pos_y     = out_y_reg;
    assign m_heading   = out_h_reg;
    assign m_lin_speed = out_v_reg;
    assign m_yaw_rate  = out_w_reg;

    a_cordic_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cordic_busy)
        else $error("cordic not running after request accept");
    a_trig_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MX || state_reg == ST_MY) |-> !cordic_busy)
        else $error("position product issued before cordic finished");
    a_zero_dt_heading: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld_head && dt_reg == 16'd0) |-> (heading_next == heading_reg))
        else $error("heading moved with zero elapsed time");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_out |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

endmodule
